FILE: hw/rtl/fat_cluster_chain_engine_defines.svh
// ----------------------------------------------------------------------------
// FAT cluster chain engine assertion macros
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FAT_CLUSTER_CHAIN_ENGINE_DEFINES_SVH
`define FAT_CLUSTER_CHAIN_ENGINE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define FCCE_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fcce check failed");
`define FCCE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fcce check failed");
`else
`define FCCE_ASSERT_SAME(lbl, ante, cons)
`define FCCE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: hw/rtl/fcce_pkg.sv
// ----------------------------------------------------------------------------
// FAT cluster chain engine package
// Table geometry, entry markers, opcodes, status codes and the remainder
// unit's request and response.
// ----------------------------------------------------------------------------
package fcce_pkg;

  localparam int unsigned TABLE_ENTRIES = 4096;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int unsigned ENTRY_W       = 28;
  localparam int unsigned OFFSET_W      = 32;
  localparam int unsigned SHIFT_W       = 5;
  localparam int unsigned PER_W         = $clog2(TABLE_ENTRIES + 1);

  localparam logic [ENTRY_W-1:0] END_MARK      = 28'h0FFFFFFF;
  localparam logic [ENTRY_W-1:0] END_THRESHOLD = 28'h0FFFFFF8;
  localparam logic [IDX_W-1:0]   ALLOC_START   = IDX_W'(2);
  localparam logic [IDX_W-1:0]   LAST_INDEX    = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [SHIFT_W-1:0] SHIFT_RESET   = 5'd12;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_ALLOC = 2'd2,
    OP_SEEK  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_ENDED   = 2'd2,
    ST_OUTSIDE = 2'd3
  } status_t;

  typedef struct packed {
    logic                start;
    logic [OFFSET_W-1:0] dividend;
    logic [PER_W-1:0]    divisor;
  } rem_req_t;

  typedef struct packed {
    logic             done;
    logic [PER_W-1:0] remainder;
  } rem_rsp_t;

  function automatic logic in_table(input logic [ENTRY_W-1:0] v);
    return {1'b0, v} < (ENTRY_W + 1)'(TABLE_ENTRIES);
  endfunction

endpackage

FILE: hw/rtl/fat_cluster_chain_engine.sv
// ----------------------------------------------------------------------------
// FAT cluster chain engine
// After reset the table is cleared one entry per cycle with in_ready low;
// cfg writes are taken at any time. One transaction is worked at a time and
// its result waits in an output register, so the next transaction is taken
// while a result is still held. From acceptance to result loaded, a write
// reads no table entry, while a read, allocate or seek reads table entries
// (a read reads one entry, an allocate one per entry scanned from index 2, a
// seek one per hop; none for a read or seek of an index outside the table or
// a seek of zero hops). These reads all go through the single table RAM read
// port, which has registered read data; a full output register holds the
// result until it is taken. A seek that completes 4096 hops on a loop
// measures the loop by following its links, reduces the rest of the hop count
// modulo its length in a remainder unit that works one offset bit at a time
// after the load, and walks the leftover hops.
// ----------------------------------------------------------------------------
`include "fat_cluster_chain_engine_defines.svh"

module fat_cluster_chain_engine
  import fcce_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [SHIFT_W-1:0]  cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_opcode,
  input  logic [ENTRY_W-1:0]  in_cluster_index,
  input  logic [ENTRY_W-1:0]  in_entry_value,
  input  logic [OFFSET_W-1:0] in_byte_offset,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [ENTRY_W-1:0]  out_cluster_out,
  output logic [1:0]          out_status
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_ALLOC,
    S_WALK,
    S_PERIOD,
    S_DIV,
    S_RESP
  } state_t;

  state_t              state_r, state_nxt;
  logic [SHIFT_W-1:0]  cshift_r, cshift_nxt;
  logic [IDX_W-1:0]    addr_r, addr_nxt;
  logic [ENTRY_W-1:0]  cur_r, cur_nxt;
  logic [OFFSET_W-1:0] remain_r, remain_nxt;
  logic [PER_W-1:0]    walked_r, walked_nxt;
  logic [PER_W-1:0]    period_r, period_nxt;
  logic                folded_r, folded_nxt;
  logic [ENTRY_W-1:0]  res_cl_r, res_cl_nxt;
  status_t             res_st_r, res_st_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [ENTRY_W-1:0]  out_cl_r, out_cl_nxt;
  status_t             out_st_r, out_st_nxt;

  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  logic [ENTRY_W-1:0]  mem_wdata;
  logic                mem_re;
  logic [IDX_W-1:0]    mem_raddr;
  logic [ENTRY_W-1:0]  mem_rdata;

  rem_req_t            rem_req;
  rem_rsp_t            rem_rsp;

  logic [OFFSET_W-1:0] hops;
  logic [OFFSET_W-1:0] remain_dec;
  logic [PER_W-1:0]    walked_inc;
  logic                idx_inside;
  logic                rdata_inside;
  logic                out_failed;

  fcce_ram #(
    .DEPTH (TABLE_ENTRIES),
    .WIDTH (ENTRY_W),
    .ADDR_W(IDX_W)
  ) u_table (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  fcce_rem u_rem (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (rem_req),
    .rsp  (rem_rsp)
  );

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_cluster_out = out_cl_r;
  assign out_status      = out_st_r;

  assign hops         = in_byte_offset >> cshift_r;
  assign remain_dec   = remain_r - OFFSET_W'(1);
  assign walked_inc   = walked_r + PER_W'(1);
  assign idx_inside   = in_table(in_cluster_index);
  assign rdata_inside = in_table(mem_rdata);
  assign out_failed   = (out_st_r == ST_FULL) || (out_st_r == ST_OUTSIDE);

  always_comb begin
    state_nxt     = state_r;
    cshift_nxt    = cfg_we ? cfg_wdata : cshift_r;
    addr_nxt      = addr_r;
    cur_nxt       = cur_r;
    remain_nxt    = remain_r;
    walked_nxt    = walked_r;
    period_nxt    = period_r;
    folded_nxt    = folded_r;
    res_cl_nxt    = res_cl_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_cl_nxt    = out_cl_r;
    out_st_nxt    = out_st_r;
    mem_we        = 1'b0;
    mem_waddr     = addr_r;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = cur_r[IDX_W-1:0];
    rem_req       = '0;

    case (state_r)
      S_CLEAR: begin
        mem_we   = 1'b1;
        addr_nxt = addr_r + IDX_W'(1);
        if (addr_r == LAST_INDEX) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          cur_nxt    = in_cluster_index;
          res_cl_nxt = '0;
          res_st_nxt = idx_inside ? ST_OK : ST_OUTSIDE;
          state_nxt  = S_RESP;
          case (opcode_t'(in_opcode))
            OP_READ: begin
              if (idx_inside) begin
                mem_re    = 1'b1;
                mem_raddr = in_cluster_index[IDX_W-1:0];
                state_nxt = S_READ;
              end
            end
            OP_WRITE: begin
              mem_we    = idx_inside;
              mem_waddr = in_cluster_index[IDX_W-1:0];
              mem_wdata = in_entry_value;
            end
            OP_ALLOC: begin
              mem_re    = 1'b1;
              mem_raddr = ALLOC_START;
              addr_nxt  = ALLOC_START;
              state_nxt = S_ALLOC;
            end
            OP_SEEK: begin
              remain_nxt = hops;
              walked_nxt = '0;
              folded_nxt = 1'b0;
              if (idx_inside) begin
                if (hops == '0) begin
                  res_cl_nxt = in_cluster_index;
                end else begin
                  mem_re    = 1'b1;
                  mem_raddr = in_cluster_index[IDX_W-1:0];
                  state_nxt = S_WALK;
                end
              end
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end

      S_READ: begin
        res_cl_nxt = mem_rdata;
        res_st_nxt = ST_OK;
        state_nxt  = S_RESP;
      end

      S_ALLOC: begin
        if (mem_rdata == '0) begin
          mem_we     = 1'b1;
          mem_waddr  = addr_r;
          mem_wdata  = END_MARK;
          res_cl_nxt = ENTRY_W'(addr_r);
          res_st_nxt = ST_OK;
          state_nxt  = S_RESP;
        end else if (addr_r == LAST_INDEX) begin
          res_cl_nxt = '0;
          res_st_nxt = ST_FULL;
          state_nxt  = S_RESP;
        end else begin
          addr_nxt  = addr_r + IDX_W'(1);
          mem_re    = 1'b1;
          mem_raddr = addr_r + IDX_W'(1);
        end
      end

      S_WALK: begin
        if (mem_rdata >= END_THRESHOLD) begin
          res_cl_nxt = cur_r;
          res_st_nxt = ST_ENDED;
          state_nxt  = S_RESP;
        end else begin
          cur_nxt    = mem_rdata;
          remain_nxt = remain_dec;
          if (!folded_r) begin
            walked_nxt = walked_inc;
          end
          if (remain_dec == '0) begin
            res_cl_nxt = mem_rdata;
            res_st_nxt = ST_OK;
            state_nxt  = S_RESP;
          end else if (!rdata_inside) begin
            res_cl_nxt = '0;
            res_st_nxt = ST_OUTSIDE;
            state_nxt  = S_RESP;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = mem_rdata[IDX_W-1:0];
            if (!folded_r && walked_inc == PER_W'(TABLE_ENTRIES)) begin
              folded_nxt = 1'b1;
              period_nxt = PER_W'(1);
              state_nxt  = S_PERIOD;
            end
          end
        end
      end

      S_PERIOD: begin
        if (mem_rdata == cur_r) begin
          rem_req.start    = 1'b1;
          rem_req.dividend = remain_r;
          rem_req.divisor  = period_r;
          state_nxt        = S_DIV;
        end else begin
          mem_re     = 1'b1;
          mem_raddr  = mem_rdata[IDX_W-1:0];
          period_nxt = period_r + PER_W'(1);
        end
      end

      S_DIV: begin
        if (rem_rsp.done) begin
          remain_nxt = OFFSET_W'(rem_rsp.remainder);
          if (rem_rsp.remainder == '0) begin
            res_cl_nxt = cur_r;
            res_st_nxt = ST_OK;
            state_nxt  = S_RESP;
          end else begin
            mem_re    = 1'b1;
            state_nxt = S_WALK;
          end
        end
      end

      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_cl_nxt    = res_cl_r;
          out_st_nxt    = res_st_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cshift_r    <= SHIFT_RESET;
      addr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cshift_r    <= cshift_nxt;
      addr_r      <= addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r    <= cur_nxt;
    remain_r <= remain_nxt;
    walked_r <= walked_nxt;
    period_r <= period_nxt;
    folded_r <= folded_nxt;
    res_cl_r <= res_cl_nxt;
    res_st_r <= res_st_nxt;
    out_cl_r <= out_cl_nxt;
    out_st_r <= out_st_nxt;
  end

  `FCCE_ASSERT_SAME(a_no_port_clash, mem_we && mem_re, mem_waddr != mem_raddr)
  `FCCE_ASSERT_SAME(a_rem_done_in_div, rem_rsp.done, state_r == S_DIV)
  `FCCE_ASSERT_SAME(a_fail_gives_zero, out_valid_r && out_failed, out_cl_r == '0)

endmodule

FILE: hw/rtl/fcce_ram.sv
// ----------------------------------------------------------------------------
// FAT cluster chain engine table RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fcce_ram #(
  parameter int unsigned DEPTH  = 4096,
  parameter int unsigned WIDTH  = 28,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/fcce_rem.sv
// ----------------------------------------------------------------------------
// FAT cluster chain engine remainder unit
// Restoring remainder of a hop count by a chain period, one bit per cycle.
// ----------------------------------------------------------------------------
module fcce_rem
  import fcce_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  rem_req_t req,
  output rem_rsp_t rsp
);

  localparam int unsigned CNT_W = $clog2(OFFSET_W + 1);

  logic                busy_r;
  logic                done_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [OFFSET_W-1:0] quo_r;
  logic [PER_W-1:0]    div_r;
  logic [PER_W-1:0]    rem_r;
  logic [PER_W:0]      trial;
  logic [PER_W:0]      trial_sub;

  always_comb begin
    trial     = {rem_r, quo_r[OFFSET_W-1]};
    trial_sub = (trial >= {1'b0, div_r}) ? (trial - {1'b0, div_r}) : trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(OFFSET_W);
        quo_r  <= req.dividend;
        div_r  <= req.divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= trial_sub[PER_W-1:0];
        quo_r <= {quo_r[OFFSET_W-2:0], 1'b0};
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done_r;
  assign rsp.remainder = rem_r;

endmodule
